>>> sv/ptt_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic task timer table: transaction structs, codes
// and the command/status structs between controller and datapath. No dependencies.

package ptt_pkg;

  // fixed field widths
  localparam int ACC_W  = 32;
  localparam int IVAL_W = 32;
  localparam int ID_W   = 4;
  localparam int CMD_W  = 2;
  localparam int KIND_W = 3;

  // input operation codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] K_FIRED   = 3'd0;
  localparam logic [KIND_W-1:0] K_ADDED   = 3'd1;
  localparam logic [KIND_W-1:0] K_FULL    = 3'd2;
  localparam logic [KIND_W-1:0] K_REMOVED = 3'd3;
  localparam logic [KIND_W-1:0] K_MISSING = 3'd4;

  // input transaction
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IVAL_W-1:0] interval;
    logic [ID_W-1:0]   task_id;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id_res;
    logic              last;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              tick_inc;
    logic              svc_start;
    logic              idx_clr;
    logic              idx_inc;
    logic              svc_rd;
    logic              rm_rd;
    logic              add_commit;
    logic              rm_commit;
    logic              svc_flush;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic count_zero;
    logic rid_ok;
    logic slot_free;
    logic idx_last;
  } ctl_stat_t;

endpackage

>>> sv/ptt_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// No dependencies.

module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ptt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the periodic task timer table.
// Depends on ptt_pkg for command/status structs and operation codes.

module ptt_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ptt_pkg::CMD_W-1:0]      op,
  input  ptt_pkg::ctl_stat_t             sts,
  output logic                           busy,
  output ptt_pkg::ctl_cmd_t              ctl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_SCAN = 4'd1;
  localparam logic [3:0] S_RM_CHECK = 4'd2;
  localparam logic [3:0] S_RM_WALK  = 4'd3;
  localparam logic [3:0] S_RM_DRAIN = 4'd4;
  localparam logic [3:0] S_SVC_WALK = 4'd5;
  localparam logic [3:0] S_SVC_D1   = 4'd6;
  localparam logic [3:0] S_SVC_D2   = 4'd7;
  localparam logic [3:0] S_SVC_FLSH = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (op)
            ptt_pkg::CMD_TICK: begin
              ctl.tick_inc = 1'b1;
            end
            ptt_pkg::CMD_SERVICE: begin
              ctl.svc_start = 1'b1;
              if (!sts.count_zero) begin
                ctl.idx_clr = 1'b1;
                state_next  = S_SVC_WALK;
              end
            end
            ptt_pkg::CMD_ADD: begin
              if (sts.full) begin
                ctl.emit      = 1'b1;
                ctl.emit_kind = ptt_pkg::K_FULL;
              end else begin
                ctl.idx_clr = 1'b1;
                state_next  = S_ADD_SCAN;
              end
            end
            default: begin
              state_next = S_RM_CHECK;
            end
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (sts.slot_free) begin
          ctl.add_commit = 1'b1;
          ctl.emit       = 1'b1;
          ctl.emit_kind  = ptt_pkg::K_ADDED;
          state_next     = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_RM_CHECK: begin
        if (sts.rid_ok) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_RM_WALK;
        end else begin
          ctl.emit      = 1'b1;
          ctl.emit_kind = ptt_pkg::K_MISSING;
          state_next    = S_IDLE;
        end
      end
      S_RM_WALK: begin
        ctl.rm_rd = 1'b1;
        if (sts.idx_last) begin
          state_next = S_RM_DRAIN;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_RM_DRAIN: begin
        ctl.rm_commit = 1'b1;
        ctl.emit      = 1'b1;
        ctl.emit_kind = ptt_pkg::K_REMOVED;
        state_next    = S_IDLE;
      end
      S_SVC_WALK: begin
        ctl.svc_rd = 1'b1;
        if (sts.idx_last) begin
          state_next = S_SVC_D1;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_SVC_D1: begin
        state_next = S_SVC_D2;
      end
      S_SVC_D2: begin
        state_next = S_SVC_FLSH;
      end
      S_SVC_FLSH: begin
        ctl.svc_flush = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/ptt_dpath.sv
`timescale 1ns / 1ps
// Datapath of the periodic task timer table: tick accumulator, slot flags,
// order list and slot RAMs, service pipeline and result register.
// Depends on ptt_pkg and ptt_ram.

module ptt_dpath #(
  parameter int MAX_TASKS     = 16,
  parameter int INTERVAL_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ptt_pkg::item_t      item,
  input  ptt_pkg::ctl_cmd_t   ctl,
  output ptt_pkg::ctl_stat_t  sts,
  output logic                res_valid,
  output ptt_pkg::result_t    result
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int IVW    = INTERVAL_BITS;
  localparam int ACCW   = ptt_pkg::ACC_W;
  localparam int IDW    = ptt_pkg::ID_W;

  logic [ACCW-1:0]      tick_accum;
  logic [ACCW-1:0]      elapsed;
  logic [IVW-1:0]       ival_q;
  logic [IDW-1:0]       rid_q;
  logic [SLOT_W-1:0]    idx;
  logic [CNT_W-1:0]     count;
  logic [MAX_TASKS-1:0] used;

  // service pipeline and remove walk stages
  logic                 s1_v;
  logic                 s2_v;
  logic [SLOT_W-1:0]    s2_slot;
  logic                 pend_v;
  logic [SLOT_W-1:0]    pend_slot;
  logic                 r1_v;
  logic [SLOT_W-1:0]    r1_idx;
  logic                 found;

  // ram ports
  logic                 ord_we;
  logic [SLOT_W-1:0]    ord_waddr;
  logic [SLOT_W-1:0]    ord_wdata;
  logic [SLOT_W-1:0]    ord_rdata;
  logic                 rem_we;
  logic [SLOT_W-1:0]    rem_waddr;
  logic [IVW-1:0]       rem_wdata;
  logic [IVW-1:0]       rem_rdata;
  logic [IVW-1:0]       int_rdata;

  logic [SLOT_W-1:0]    rid_slot;
  logic [ACCW-1:0]      rem_ext;
  logic                 fire;
  logic [IVW-1:0]       rem_sub;
  logic [IDW-1:0]       emit_id;

  assign rid_slot = SLOT_W'(rid_q);
  assign rem_ext  = ACCW'(rem_rdata);
  assign fire     = (rem_ext <= elapsed);
  assign rem_sub  = IVW'(rem_ext - elapsed);

  // status to controller
  assign sts.full       = (count >= CNT_W'(MAX_TASKS));
  assign sts.count_zero = (count == '0);
  assign sts.rid_ok     = (32'(rid_q) < MAX_TASKS) && used[rid_slot];
  assign sts.slot_free  = !used[idx];
  assign sts.idx_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // order list writes: append on add, shift down behind the removed entry
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = idx;
    ord_wdata = idx;
    if (ctl.add_commit) begin
      ord_we    = 1'b1;
      ord_waddr = count[SLOT_W-1:0];
      ord_wdata = idx;
    end else if (r1_v && found) begin
      ord_we    = 1'b1;
      ord_waddr = r1_idx - SLOT_W'(1);
      ord_wdata = ord_rdata;
    end
  end

  // remaining count writes: load on add, update or reload on service
  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = idx;
    rem_wdata = ival_q;
    if (ctl.add_commit) begin
      rem_we = 1'b1;
    end else if (s2_v) begin
      rem_we    = 1'b1;
      rem_waddr = s2_slot;
      rem_wdata = fire ? int_rdata : rem_sub;
    end
  end

  ptt_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (idx),
    .rdata (ord_rdata)
  );

  ptt_ram #(.WIDTH(IVW), .DEPTH(MAX_TASKS)) u_interval_ram (
    .clk   (clk),
    .we    (ctl.add_commit),
    .waddr (idx),
    .wdata (ival_q),
    .raddr (ord_rdata),
    .rdata (int_rdata)
  );

  ptt_ram #(.WIDTH(IVW), .DEPTH(MAX_TASKS)) u_remain_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (ord_rdata),
    .rdata (rem_rdata)
  );

  // transaction payload latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ival_q <= item.interval[IVW-1:0];
      rid_q  <= item.task_id;
    end
  end

  // tick accumulator and elapsed snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_accum <= '0;
    end else if (ctl.tick_inc) begin
      tick_accum <= tick_accum + ACCW'(1);
    end else if (ctl.svc_start) begin
      tick_accum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.svc_start) begin
      elapsed <= tick_accum;
    end
  end

  // walk index
  always_ff @(posedge clk) begin
    if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  // task count and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= '0;
    end else if (ctl.add_commit) begin
      count     <= count + CNT_W'(1);
      used[idx] <= 1'b1;
    end else if (ctl.rm_commit) begin
      count          <= count - CNT_W'(1);
      used[rid_slot] <= 1'b0;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      r1_v  <= 1'b0;
      found <= 1'b0;
    end else begin
      s1_v <= ctl.svc_rd;
      s2_v <= s1_v;
      r1_v <= ctl.rm_rd;
      if (ctl.load) begin
        found <= 1'b0;
      end else if (r1_v && (ord_rdata == rid_slot)) begin
        found <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s2_slot <= ord_rdata;
    r1_idx  <= idx;
  end

  // held fired result, released once the next one or the end is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (s2_v && fire) begin
      pend_v <= 1'b1;
    end else if (ctl.svc_flush || ctl.svc_start) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v && fire) begin
      pend_slot <= s2_slot;
    end
  end

  // id for single results
  always_comb begin
    case (ctl.emit_kind)
      ptt_pkg::K_ADDED:   emit_id = IDW'(idx);
      ptt_pkg::K_REMOVED: emit_id = rid_q;
      ptt_pkg::K_MISSING: emit_id = rid_q;
      default:            emit_id = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= ctl.emit || (pend_v && ((s2_v && fire) || ctl.svc_flush));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result.kind        <= ctl.emit_kind;
      result.task_id_res <= emit_id;
      result.last        <= 1'b1;
    end else begin
      result.kind        <= ptt_pkg::K_FIRED;
      result.task_id_res <= IDW'(pend_slot);
      result.last        <= ctl.svc_flush;
    end
  end

  // slot flags and task count agree
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == 32'(count))
    else $error("slot flag population differs from task count");

  // an add only claims a free slot
  a_add_free: assert property (@(posedge clk) disable iff (rst)
    ctl.add_commit |-> !used[idx])
    else $error("add commits into a used slot");

  // single results never collide with the service pipeline
  a_emit_clash: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !(s2_v || s1_v || pend_v))
    else $error("single result issued during service walk");

  // a remove commits only after the walk met the task
  a_rm_found: assert property (@(posedge clk) disable iff (rst)
    ctl.rm_commit |-> (found || (r1_v && (ord_rdata == rid_slot))))
    else $error("remove commit without locating the task");

endmodule

>>> sv/periodic_task_timer_table.sv
`timescale 1ns / 1ps
// Top level of the periodic task timer table: controller plus datapath.
// Depends on ptt_pkg, ptt_ctrl, ptt_dpath (and ptt_ram below it).
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------
//   input     | start in, busy out        | item   (cmd, interval, task_id)
//   result    | res_valid out, one cycle  | result (kind, task_id_res, last)
//
// per operation, N = tasks: tick steps the accumulator; service of an empty table
// stays idle, else walks the N list entries one per cycle through the order RAM, then
// drains the slot RAM read pipeline; add answers a full table without a scan, else
// checks one slot flag per cycle until a free one; remove walks all N for a known id.
// reset: synchronous, clears the accumulator, task count and slot flags; no sweep.
// results leave as one-cycle strobes and cannot be stalled; busy holds off start.

module periodic_task_timer_table #(
  parameter int MAX_TASKS     = 16,
  parameter int INTERVAL_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ptt_pkg::item_t   item,
  output logic             res_valid,
  output ptt_pkg::result_t result
);

  ptt_pkg::ctl_cmd_t  ctl;
  ptt_pkg::ctl_stat_t sts;

  ptt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.cmd),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  ptt_dpath #(
    .MAX_TASKS     (MAX_TASKS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res_valid),
    .result    (result)
  );

endmodule
